// File: rtl/cbi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbi_pkg
// shared types, constants and helpers of the corridor box inflation block
// ----------------------------------------------------------------------------
package cbi_pkg;

	localparam int MAP_SIDE        = 256;
	localparam int COORD_FRAC_BITS = 4;
	localparam int ADDR_W          = $clog2(MAP_SIDE * MAP_SIDE);
	localparam int COORD_W         = 16;
	localparam int EXT_W           = COORD_W + 2;
	localparam int DIM_W           = 9;
	localparam int THR_W           = 7;
	localparam int IDX_W           = 2 * DIM_W + 1;

	localparam logic signed [EXT_W-1:0] CELL_STEP = EXT_W'(1 << COORD_FRAC_BITS);
	localparam logic signed [EXT_W-1:0] HALF_CELL = EXT_W'(1 << (COORD_FRAC_BITS - 1));
	localparam logic signed [7:0] CELL_UNKNOWN = -8'sd1;

	localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(65);
	localparam logic [DIM_W-1:0] WIDTH_RESET     = DIM_W'(256);
	localparam logic [DIM_W-1:0] HEIGHT_RESET    = DIM_W'(256);

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_POINT = 2'd1,
		CMD_END   = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_WIDTH     = 2'd1,
		REG_HEIGHT    = 2'd2,
		REG_SPARE     = 2'd3
	} reg_t;

	typedef enum logic [1:0] {
		SIDE_XMIN = 2'd0,
		SIDE_XMAX = 2'd1,
		SIDE_YMIN = 2'd2,
		SIDE_YMAX = 2'd3
	} side_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SIDE,
		ST_SCAN
	} state_t;

	// map settings handed to the engine
	typedef struct packed {
		logic [THR_W-1:0] threshold;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} map_cfg_t;

	// side visited at step k of a round in the given growth order
	function automatic side_t side_at(input logic [1:0] order, input logic [1:0] k);
		side_t s;
		begin
			s = SIDE_XMIN;
			case (order)
				2'd0: case (k)
					2'd0: s = SIDE_XMIN;
					2'd1: s = SIDE_YMIN;
					2'd2: s = SIDE_XMAX;
					default: s = SIDE_YMAX;
				endcase
				2'd1: case (k)
					2'd0: s = SIDE_YMIN;
					2'd1: s = SIDE_XMIN;
					2'd2: s = SIDE_XMAX;
					default: s = SIDE_YMAX;
				endcase
				2'd2: case (k)
					2'd0: s = SIDE_XMAX;
					2'd1: s = SIDE_XMIN;
					2'd2: s = SIDE_YMIN;
					default: s = SIDE_YMAX;
				endcase
				default: case (k)
					2'd0: s = SIDE_YMAX;
					2'd1: s = SIDE_XMIN;
					2'd2: s = SIDE_YMIN;
					default: s = SIDE_XMAX;
				endcase
			endcase
			return s;
		end
	endfunction

	function automatic logic signed [EXT_W-1:0] ext(input logic signed [COORD_W-1:0] v);
		return EXT_W'(v);
	endfunction

endpackage
`default_nettype wire

// File: rtl/corridor_box_inflation_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// corridor_box_inflation_top
// grows obstacle-free boxes along a path over an occupancy map
// ----------------------------------------------------------------------------
// A map write leaves busy low. A path point inside the open box goes from
// evaluation straight back to idle; otherwise each growth round visits the
// four sides, a side that still grows reads its edge cells from the map store
// through its single read port until a cell blocks or the edge is free, and
// each round ends with an evaluation step. An emitted box is shown for
// exactly one cycle with box_valid and must be taken then: the receiver
// cannot stall. Configuration must be written only while busy is low; the
// block itself does not enforce it.
module corridor_box_inflation_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [1:0]                         cfg_index,
	input  wire logic [cbi_pkg::DIM_W-1:0]          cfg_wdata,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [1:0]                         command,
	input  wire logic [15:0]                        cell_address,
	input  wire logic signed [7:0]                  cell_value,
	input  wire logic signed [cbi_pkg::COORD_W-1:0] point_x,
	input  wire logic signed [cbi_pkg::COORD_W-1:0] point_y,
	output logic                                    box_valid,
	output logic signed [cbi_pkg::COORD_W-1:0]      box_x_min,
	output logic signed [cbi_pkg::COORD_W-1:0]      box_x_max,
	output logic signed [cbi_pkg::COORD_W-1:0]      box_y_min,
	output logic signed [cbi_pkg::COORD_W-1:0]      box_y_max,
	output logic                                    last_box,
	output logic                                    joins_previous
);
	import cbi_pkg::*;

	map_cfg_t cfg_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= THRESHOLD_RESET;
			cfg_q.width     <= WIDTH_RESET;
			cfg_q.height    <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: cfg_q.threshold <= cfg_wdata[THR_W-1:0];
				REG_WIDTH:     cfg_q.width     <= cfg_wdata;
				REG_HEIGHT:    cfg_q.height    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	cbi_engine u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.cell_address   (cell_address),
		.cell_value     (cell_value),
		.point_x        (point_x),
		.point_y        (point_y),
		.box_valid      (box_valid),
		.box_x_min      (box_x_min),
		.box_x_max      (box_x_max),
		.box_y_min      (box_y_min),
		.box_y_max      (box_y_max),
		.last_box       (last_box),
		.joins_previous (joins_previous)
	);

endmodule
`default_nettype wire

// File: rtl/cbi_occ_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbi_occ_mem
// occupancy map store, one write and one registered read port
// ----------------------------------------------------------------------------
module cbi_occ_mem (
	input  wire logic                      clk,
	input  wire logic                      wr_en,
	input  wire logic [cbi_pkg::ADDR_W-1:0] wr_addr,
	input  wire logic [7:0]                wr_data,
	input  wire logic                      rd_en,
	input  wire logic [cbi_pkg::ADDR_W-1:0] rd_addr,
	output logic      [7:0]                rd_data
);
	import cbi_pkg::*;

	logic [7:0] mem [2**ADDR_W];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// File: rtl/cbi_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbi_engine
// box growth sequencer: scans edge cells through the map store, one per cycle
// ----------------------------------------------------------------------------
module cbi_engine (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire cbi_pkg::map_cfg_t                  cfg,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [1:0]                         command,
	input  wire logic [15:0]                        cell_address,
	input  wire logic signed [7:0]                  cell_value,
	input  wire logic signed [cbi_pkg::COORD_W-1:0] point_x,
	input  wire logic signed [cbi_pkg::COORD_W-1:0] point_y,
	output logic                                    box_valid,
	output logic signed [cbi_pkg::COORD_W-1:0]      box_x_min,
	output logic signed [cbi_pkg::COORD_W-1:0]      box_x_max,
	output logic signed [cbi_pkg::COORD_W-1:0]      box_y_min,
	output logic signed [cbi_pkg::COORD_W-1:0]      box_y_max,
	output logic                                    last_box,
	output logic                                    joins_previous
);
	import cbi_pkg::*;

	state_t state_q, state_d;

	logic signed [COORD_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic signed [COORD_W-1:0] px_min_q, px_max_q, py_min_q, py_max_q;
	logic signed [COORD_W-1:0] pt_x_q, pt_y_q;
	logic [3:0]                grow_q;
	logic                      open_q, have_prev_q, final_q;
	logic [1:0]                order_q, k_q;
	logic signed [EXT_W-1:0]   edge_q, v_q, v_end_q;
	logic                      issue_q;
	logic                      pend_s1, oob_s1, last_s1;

	logic                      accept, wr_en, issuing, emit;
	logic                      contained, any_grow, cur_grow, x_side;
	side_t                     cur_side;
	logic [1:0]                order_pick;
	logic signed [EXT_W-1:0]   qx, qy, cx, cy;
	logic [IDX_W-1:0]          idx;
	logic                      oob;
	logic [7:0]                rd_data;
	logic                      val_blocked, blocked, done_free, scan_end, joins;
	logic signed [EXT_W-1:0]   new_edge, other_min, other_max;

	cbi_occ_mem u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cell_address[ADDR_W-1:0]),
		.wr_data (cell_value),
		.rd_en   (issuing),
		.rd_addr (idx[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	// control decode
	always_comb begin
		busy     = (state_q != ST_IDLE);
		accept   = start && (state_q == ST_IDLE);
		wr_en    = accept && (command == CMD_WRITE)
			&& ({16'd0, cell_address} < 32'(MAP_SIDE * MAP_SIDE));
		issuing  = (state_q == ST_SCAN) && issue_q;
		any_grow = |grow_q;
		cur_side = side_at(order_q, k_q);
		cur_grow = grow_q[cur_side];
		x_side   = (cur_side == SIDE_XMIN) || (cur_side == SIDE_XMAX);
		emit     = (state_q == ST_EVAL) && !any_grow && (final_q || !contained);
	end

	// point against the open box widened by half a cell, and growth order
	always_comb begin
		contained = (ext(pt_x_q) >= ext(x_min_q) - HALF_CELL)
			&& (ext(pt_x_q) <= ext(x_max_q) + HALF_CELL)
			&& (ext(pt_y_q) >= ext(y_min_q) - HALF_CELL)
			&& (ext(pt_y_q) <= ext(y_max_q) + HALF_CELL);
		if (pt_x_q < x_min_q)
			order_pick = 2'd0;
		else if (pt_y_q < y_min_q)
			order_pick = 2'd1;
		else if (pt_x_q > x_max_q)
			order_pick = 2'd2;
		else
			order_pick = 2'd3;
	end

	// new edge line and its span for the side being set up
	always_comb begin
		unique case (cur_side)
			SIDE_XMIN: new_edge = ext(x_min_q) - CELL_STEP;
			SIDE_XMAX: new_edge = ext(x_max_q) + CELL_STEP;
			SIDE_YMIN: new_edge = ext(y_min_q) - CELL_STEP;
			SIDE_YMAX: new_edge = ext(y_max_q) + CELL_STEP;
			default:   new_edge = ext(x_min_q);
		endcase
		other_min = x_side ? ext(y_min_q) : ext(x_min_q);
		other_max = x_side ? ext(y_max_q) : ext(x_max_q);
	end

	// cell index of the current scan position
	always_comb begin
		qx  = x_side ? edge_q : v_q;
		qy  = x_side ? v_q : edge_q;
		cx  = qx >>> COORD_FRAC_BITS;
		cy  = qy >>> COORD_FRAC_BITS;
		idx = IDX_W'(cx[DIM_W-1:0]) + IDX_W'(cy[DIM_W-1:0]) * IDX_W'(cfg.width);
		oob = cx[EXT_W-1] || cy[EXT_W-1]
			|| (cx >= $signed({1'b0, EXT_W'(cfg.width)}))
			|| (cy >= $signed({1'b0, EXT_W'(cfg.height)}))
			|| (idx[IDX_W-1:ADDR_W] != '0);
	end

	// check of the cell read in the previous cycle
	always_comb begin
		val_blocked = ($signed(rd_data) >= $signed({1'b0, cfg.threshold}))
			|| ($signed(rd_data) == CELL_UNKNOWN);
		blocked   = pend_s1 && (oob_s1 || val_blocked);
		done_free = pend_s1 && !blocked && last_s1;
		scan_end  = blocked || done_free;
	end

	// overlap with the previous box
	always_comb begin
		logic signed [COORD_W-1:0] lx, hx, ly, hy;
		lx = (x_min_q > px_min_q) ? x_min_q : px_min_q;
		hx = (x_max_q < px_max_q) ? x_max_q : px_max_q;
		ly = (y_min_q > py_min_q) ? y_min_q : py_min_q;
		hy = (y_max_q < py_max_q) ? y_max_q : py_max_q;
		joins = !have_prev_q || ((hx >= lx) && (hy >= ly));
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:
				if (accept && open_q && (command == CMD_POINT || command == CMD_END))
					state_d = ST_EVAL;
			ST_EVAL:
				if (final_q)
					state_d = any_grow ? ST_SIDE : ST_IDLE;
				else if (contained || !any_grow)
					state_d = ST_IDLE;
				else
					state_d = ST_SIDE;
			ST_SIDE:
				if (cur_grow)
					state_d = ST_SCAN;
				else if (k_q == 2'd3)
					state_d = ST_EVAL;
			ST_SCAN:
				if (scan_end)
					state_d = (k_q == 2'd3) ? ST_EVAL : ST_SIDE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// box state, scan pointer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= '0; x_max_q <= '0; y_min_q <= '0; y_max_q <= '0;
			px_min_q <= '0; px_max_q <= '0; py_min_q <= '0; py_max_q <= '0;
			grow_q <= '1;
			open_q <= 1'b0;
			have_prev_q <= 1'b0;
			final_q <= 1'b0;
			order_q <= '0;
			k_q <= '0;
			issue_q <= 1'b0;
			pend_s1 <= 1'b0;
			box_valid <= 1'b0;
		end else begin
			box_valid <= emit;
			pend_s1 <= issuing && !scan_end;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && command == CMD_POINT) begin
						pt_x_q <= point_x;
						pt_y_q <= point_y;
						final_q <= 1'b0;
						if (!open_q) begin
							x_min_q <= point_x; x_max_q <= point_x;
							y_min_q <= point_y; y_max_q <= point_y;
							grow_q <= '1;
							open_q <= 1'b1;
						end
					end else if (accept && command == CMD_END) begin
						final_q <= 1'b1;
					end
				end
				ST_EVAL: begin
					if (final_q && any_grow) begin
						order_q <= 2'd0;
						k_q <= 2'd0;
					end else if (!final_q && !contained && any_grow) begin
						order_q <= order_pick;
						k_q <= 2'd0;
					end else if (emit) begin
						// emit the finished box
						box_x_min <= x_min_q; box_x_max <= x_max_q;
						box_y_min <= y_min_q; box_y_max <= y_max_q;
						last_box <= final_q;
						joins_previous <= joins;
						px_min_q <= x_min_q; px_max_q <= x_max_q;
						py_min_q <= y_min_q; py_max_q <= y_max_q;
						if (final_q) begin
							open_q <= 1'b0;
							have_prev_q <= 1'b0;
						end else begin
							have_prev_q <= 1'b1;
							x_min_q <= pt_x_q; x_max_q <= pt_x_q;
							y_min_q <= pt_y_q; y_max_q <= pt_y_q;
							grow_q <= '1;
						end
					end
				end
				ST_SIDE: begin
					if (cur_grow) begin
						edge_q <= new_edge;
						v_q <= other_min;
						v_end_q <= other_max;
						issue_q <= 1'b1;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				ST_SCAN: begin
					if (issuing) begin
						v_q <= v_q + CELL_STEP;
						oob_s1 <= oob;
						last_s1 <= (v_q == v_end_q);
					end
					// stop issuing after the last cell or once the scan is decided
					if (scan_end || (issuing && (v_q == v_end_q)))
						issue_q <= 1'b0;
					if (scan_end) begin
						k_q <= k_q + 2'd1;
						if (blocked)
							grow_q[cur_side] <= 1'b0;
						else begin
							case (cur_side)
								SIDE_XMIN: x_min_q <= edge_q[COORD_W-1:0];
								SIDE_XMAX: x_max_q <= edge_q[COORD_W-1:0];
								SIDE_YMIN: y_min_q <= edge_q[COORD_W-1:0];
								default:   y_max_q <= edge_q[COORD_W-1:0];
							endcase
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire
